[hdl/psa_pkg.sv]
// Shared constants and types for the paged range suballocator.
`timescale 1ns / 1ps
package psa_pkg;

   localparam int PAGE_BYTES              = 2 * 1024 * 1024;
   localparam int SEGMENT_BYTES           = 512;
   localparam int MAX_PAGES               = 8;
   localparam int DEFAULT_MAX_FREE_RANGES = 64;
   localparam int DEFAULT_MAX_PENDING     = 64;

   localparam int AW       = 22;   // byte position inside a page, up to PAGE_BYTES
   localparam int PAGE_W   = 3;
   localparam int OFF_W    = 21;
   localparam int FENCE_W  = 64;
   localparam int REQ_W    = 32;
   localparam int ALIGN_W  = 10;
   localparam int BBYTES_W = 22;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_RETIRE = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_TOO_BIG = 2'd1;
   localparam logic [1:0] STAT_NO_PAGE = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   typedef struct packed {
      logic [AW-1:0] rng_hi;
      logic [AW-1:0] rng_lo;
   } free_entry_type;

   typedef struct packed {
      logic [FENCE_W-1:0] fence;
      logic [AW-1:0]      rng_hi;
      logic [AW-1:0]      rng_lo;
   } pend_entry_type;

   typedef struct packed {
      logic          done;
      logic          too_big;
      logic [AW-1:0] size;
   } size_result_type;

endpackage

[hdl/psa_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module psa_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/psa_size_unit.sv]
// Rounds an allocate size to its alignment (bit-serial remainder) and to whole segments.
`timescale 1ns / 1ps
module psa_size_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [psa_pkg::REQ_W-1:0]   request_bytes,
   input  logic [psa_pkg::ALIGN_W-1:0] align_bytes,
   output psa_pkg::size_result_type    result
);

   localparam int XW = psa_pkg::REQ_W + 1;
   localparam int CW = $clog2(XW + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_SUB, S_RND} size_state_type;

   size_state_type              state_ff, state_in;
   logic [XW-1:0]               x_ff, x_in;
   logic [XW-1:0]               xs_ff, xs_in;
   logic [psa_pkg::ALIGN_W-1:0] a_ff, a_in;
   logic [psa_pkg::ALIGN_W-1:0] r_ff, r_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [XW-1:0]               sz1_ff, sz1_in;
   logic                        done_ff, done_in;
   logic                        big_ff, big_in;
   logic [psa_pkg::AW-1:0]      size_ff, size_in;
   logic [psa_pkg::ALIGN_W-1:0] a_eff;
   logic [psa_pkg::ALIGN_W:0]   r_sh;
   logic [XW:0]                 sz2;

   assign a_eff = (align_bytes == '0) ? psa_pkg::ALIGN_W'(1) : align_bytes;
   assign r_sh  = {r_ff, xs_ff[XW-1]};
   assign sz2   = ({1'b0, sz1_ff} + (XW+1)'(psa_pkg::SEGMENT_BYTES - 1))
                  & ~((XW+1)'(psa_pkg::SEGMENT_BYTES - 1));

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      xs_in    = xs_ff;
      a_in     = a_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      sz1_in   = sz1_ff;
      done_in  = 1'b0;
      big_in   = big_ff;
      size_in  = size_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = XW'(request_bytes) + XW'(a_eff) - XW'(1);
               xs_in    = XW'(request_bytes) + XW'(a_eff) - XW'(1);
               a_in     = a_eff;
               r_in     = '0;
               cnt_in   = CW'(XW);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one quotient bit a cycle; only the remainder is kept
            if (r_sh >= {1'b0, a_ff}) begin
               r_in = psa_pkg::ALIGN_W'(r_sh - {1'b0, a_ff});
            end else begin
               r_in = psa_pkg::ALIGN_W'(r_sh);
            end
            xs_in  = {xs_ff[XW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            sz1_in   = x_ff - XW'(r_ff);
            state_in = S_RND;
         end
         S_RND: begin
            big_in   = sz2 > (XW+1)'(psa_pkg::PAGE_BYTES);
            size_in  = sz2[psa_pkg::AW-1:0];
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      xs_ff   <= xs_in;
      a_ff    <= a_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
      sz1_ff  <= sz1_in;
      big_ff  <= big_in;
      size_ff <= size_in;
   end

   assign result.done    = done_ff;
   assign result.too_big = big_ff;
   assign result.size    = size_ff;

endmodule

[hdl/paged_range_suballocator.sv]
// Top level: request sequencer over the free-range and pending-free memories.
//
// Channel   Dir  Signals                          Content
// req_      in   tvalid tready tdata[151:0] tuser  one allocate / free / retire / clear
// rsp_      out  tvalid tready tdata[31:0]         status, page, offset
//
// Items are handled one at a time. Allocate sizes the request, then scans the
// free-range entries and shifts later entries down when one is removed. Retire
// reads each pending entry and writes back each that stays queued; for each
// range given back it scans free entries and shifts them to make or close a gap.
// Each list memory has a single read port. Synchronous reset empties every page
// at once. A waiting response does not block the next request.
`timescale 1ns / 1ps
module paged_range_suballocator #(
   parameter int MAX_FREE_RANGES = psa_pkg::DEFAULT_MAX_FREE_RANGES,
   parameter int MAX_PENDING     = psa_pkg::DEFAULT_MAX_PENDING
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // request_bytes, align_bytes, block_page, block_offset, block_bytes, fence
   input  logic [151:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, page, offset, zero pad
   output logic [31:0]  rsp_tdata
);

   localparam int AW    = psa_pkg::AW;
   localparam int PW    = psa_pkg::PAGE_W;
   localparam int NP    = psa_pkg::MAX_PAGES;
   localparam int PCW   = $clog2(NP + 1);
   localparam int FCW   = $clog2(MAX_FREE_RANGES + 1);
   localparam int FIW   = $clog2(MAX_FREE_RANGES);
   localparam int QCW   = $clog2(MAX_PENDING + 1);
   localparam int QIW   = $clog2(MAX_PENDING);
   localparam int FAW   = PW + FIW;
   localparam int QAW   = PW + QIW;
   localparam int FQW   = AW + 2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SIZE, ST_ALLOC_PAGE, ST_ALLOC_RD, ST_ALLOC_CHK, ST_REM, ST_REM_WR,
      ST_OPEN, ST_FREE, ST_CLEAR, ST_RET_PAGE, ST_RET_RD, ST_RET_CHK, ST_KEEP,
      ST_RET_NEXT, ST_GB_RD, ST_GB_CHK, ST_GB_END, ST_INS, ST_INS_WR, ST_DONE
   } seq_state_type;

   seq_state_type              state_ff, state_in;
   logic [NP-1:0]              open_ff, open_in;
   logic [FCW-1:0]             free_cnt_ff [NP];
   logic [FCW-1:0]             free_cnt_in [NP];
   logic [QCW-1:0]             pend_cnt_ff [NP];
   logic [QCW-1:0]             pend_cnt_in [NP];
   logic [1:0]                 mode_ff, mode_in;
   logic [PW-1:0]              bpage_ff, bpage_in;
   logic [psa_pkg::OFF_W-1:0]  boff_ff, boff_in;
   logic [psa_pkg::BBYTES_W-1:0] bbytes_ff, bbytes_in;
   logic [psa_pkg::FENCE_W-1:0] fence_ff, fence_in;
   logic [AW-1:0]              sz_ff, sz_in;
   logic [1:0]                 status_ff, status_in;
   logic [PW-1:0]              opage_ff, opage_in;
   logic [psa_pkg::OFF_W-1:0]  ooff_ff, ooff_in;
   logic [PCW-1:0]             p_ff, p_in;
   logic [FCW-1:0]             idx_ff, idx_in;
   logic [FCW-1:0]             k_ff, k_in;
   logic [FCW-1:0]             pos_ff, pos_in;
   logic [QCW-1:0]             qi_ff, qi_in;
   logic [QCW-1:0]             kept_ff, kept_in;
   psa_pkg::pend_entry_type    ent_ff, ent_in;
   psa_pkg::free_entry_type    prev_ff, prev_in;
   logic                       has_prev_ff, has_prev_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [PW-1:0]              rsp_page_ff, rsp_page_in;
   logic [psa_pkg::OFF_W-1:0]  rsp_off_ff, rsp_off_in;

   logic                       f_we;
   logic [FAW-1:0]             f_waddr, f_raddr;
   psa_pkg::free_entry_type    f_wdata, fcur;
   logic                       q_we;
   logic [QAW-1:0]             q_waddr, q_raddr;
   psa_pkg::pend_entry_type    q_wdata, qcur;

   logic                       size_start;
   psa_pkg::size_result_type   size_res;

   logic [PW-1:0]              pg;
   logic [FCW-1:0]             idx_inc, k_inc, k_dec, pos_inc, pos_dec;
   logic [QCW-1:0]             qi_inc;
   logic [AW-1:0]              new_lo;
   logic [PW-1:0]              open_pg;
   logic                       open_ok;
   logic [AW-1:0]              fq_lo, fq_hi;
   logic [FQW-1:0]             fq_sum;
   logic                       prev_join;

   assign pg      = p_ff[PW-1:0];
   assign idx_inc = idx_ff + FCW'(1);
   assign k_inc   = k_ff + FCW'(1);
   assign k_dec   = k_ff - FCW'(1);
   assign pos_inc = pos_ff + FCW'(1);
   assign pos_dec = pos_ff - FCW'(1);
   assign qi_inc  = qi_ff + QCW'(1);
   assign new_lo  = fcur.rng_lo + sz_ff;
   assign prev_join = has_prev_ff && (prev_ff.rng_hi == ent_ff.rng_lo);

   // free-queue range: start down to a segment, end up to a segment, clipped at page end
   assign fq_lo  = AW'(boff_ff) & ~AW'(psa_pkg::SEGMENT_BYTES - 1);
   assign fq_sum = (FQW'(boff_ff) + FQW'(bbytes_ff) + FQW'(psa_pkg::SEGMENT_BYTES - 1))
                   & ~FQW'(psa_pkg::SEGMENT_BYTES - 1);
   assign fq_hi  = (fq_sum > FQW'(psa_pkg::PAGE_BYTES)) ? AW'(psa_pkg::PAGE_BYTES)
                                                        : fq_sum[AW-1:0];

   // lowest unopened page
   always_comb begin
      open_pg = '0;
      open_ok = 1'b0;
      for (int n = NP - 1; n >= 0; n--) begin
         if (!open_ff[n]) begin
            open_pg = PW'(n);
            open_ok = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      open_in     = open_ff;
      free_cnt_in = free_cnt_ff;
      pend_cnt_in = pend_cnt_ff;
      mode_in     = mode_ff;
      bpage_in    = bpage_ff;
      boff_in     = boff_ff;
      bbytes_in   = bbytes_ff;
      fence_in    = fence_ff;
      sz_in       = sz_ff;
      status_in   = status_ff;
      opage_in    = opage_ff;
      ooff_in     = ooff_ff;
      p_in        = p_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      pos_in      = pos_ff;
      qi_in       = qi_ff;
      kept_in     = kept_ff;
      ent_in      = ent_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      size_start  = 1'b0;
      f_we        = 1'b0;
      f_waddr     = '0;
      f_wdata     = '0;
      f_raddr     = '0;
      q_we        = 1'b0;
      q_waddr     = '0;
      q_wdata     = '0;
      q_raddr     = '0;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_off_in    = rsp_off_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               bpage_in  = req_tdata[44:42];
               boff_in   = req_tdata[65:45];
               bbytes_in = req_tdata[87:66];
               fence_in  = req_tdata[151:88];
               status_in = psa_pkg::STAT_OK;
               opage_in  = '0;
               ooff_in   = '0;
               p_in      = '0;
               case (req_tuser)
                  psa_pkg::MODE_ALLOC: begin
                     size_start = 1'b1;
                     state_in   = ST_SIZE;
                  end
                  psa_pkg::MODE_FREE:   state_in = ST_FREE;
                  psa_pkg::MODE_RETIRE: state_in = ST_RET_PAGE;
                  default:              state_in = ST_CLEAR;
               endcase
            end
         end
         ST_SIZE: begin
            if (size_res.done) begin
               if (size_res.too_big) begin
                  status_in = psa_pkg::STAT_TOO_BIG;
                  state_in  = ST_DONE;
               end else begin
                  sz_in    = size_res.size;
                  state_in = ST_ALLOC_PAGE;
               end
            end
         end
         ST_ALLOC_PAGE: begin
            if (p_ff == PCW'(NP)) begin
               state_in = ST_OPEN;
            end else if (open_ff[pg] && free_cnt_ff[pg] != '0) begin
               idx_in   = '0;
               state_in = ST_ALLOC_RD;
            end else begin
               p_in = p_ff + PCW'(1);
            end
         end
         ST_ALLOC_RD: begin
            f_raddr  = {pg, idx_ff[FIW-1:0]};
            state_in = ST_ALLOC_CHK;
         end
         ST_ALLOC_CHK: begin
            if ((fcur.rng_hi - fcur.rng_lo) >= sz_ff) begin
               opage_in = pg;
               ooff_in  = fcur.rng_lo[psa_pkg::OFF_W-1:0];
               if (new_lo == fcur.rng_hi) begin
                  k_in     = idx_ff;
                  state_in = ST_REM;
               end else begin
                  f_we     = 1'b1;
                  f_waddr  = {pg, idx_ff[FIW-1:0]};
                  f_wdata  = '{rng_hi: fcur.rng_hi, rng_lo: new_lo};
                  state_in = ST_DONE;
               end
            end else if (idx_inc < free_cnt_ff[pg]) begin
               idx_in   = idx_inc;
               state_in = ST_ALLOC_RD;
            end else begin
               p_in     = p_ff + PCW'(1);
               state_in = ST_ALLOC_PAGE;
            end
         end
         ST_REM: begin
            // close the gap at k by moving later entries down one at a time
            if (k_inc < free_cnt_ff[pg]) begin
               f_raddr  = {pg, k_inc[FIW-1:0]};
               state_in = ST_REM_WR;
            end else begin
               free_cnt_in[pg] = free_cnt_ff[pg] - FCW'(1);
               state_in = (mode_ff == psa_pkg::MODE_ALLOC) ? ST_DONE : ST_RET_NEXT;
            end
         end
         ST_REM_WR: begin
            f_we     = 1'b1;
            f_waddr  = {pg, k_ff[FIW-1:0]};
            f_wdata  = fcur;
            k_in     = k_inc;
            state_in = ST_REM;
         end
         ST_OPEN: begin
            if (!open_ok) begin
               status_in = psa_pkg::STAT_NO_PAGE;
            end else begin
               open_in[open_pg]     = 1'b1;
               pend_cnt_in[open_pg] = '0;
               free_cnt_in[open_pg] = (sz_ff < AW'(psa_pkg::PAGE_BYTES)) ? FCW'(1) : '0;
               f_we     = 1'b1;
               f_waddr  = {open_pg, FIW'(0)};
               f_wdata  = '{rng_hi: AW'(psa_pkg::PAGE_BYTES), rng_lo: sz_ff};
               opage_in = open_pg;
               ooff_in  = '0;
            end
            state_in = ST_DONE;
         end
         ST_FREE: begin
            if (bbytes_ff > psa_pkg::BBYTES_W'(psa_pkg::PAGE_BYTES)) begin
               status_in = psa_pkg::STAT_TOO_BIG;
            end else if (open_ff[bpage_ff] && fq_lo < fq_hi) begin
               if (pend_cnt_ff[bpage_ff] >= QCW'(MAX_PENDING)) begin
                  status_in = psa_pkg::STAT_FULL;
               end else begin
                  q_we    = 1'b1;
                  q_waddr = {bpage_ff, pend_cnt_ff[bpage_ff][QIW-1:0]};
                  q_wdata = '{fence: fence_ff, rng_hi: fq_hi, rng_lo: fq_lo};
                  pend_cnt_in[bpage_ff] = pend_cnt_ff[bpage_ff] + QCW'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            open_in = '0;
            for (int n = 0; n < NP; n++) begin
               free_cnt_in[n] = '0;
               pend_cnt_in[n] = '0;
            end
            state_in = ST_DONE;
         end
         ST_RET_PAGE: begin
            if (p_ff == PCW'(NP)) begin
               state_in = ST_DONE;
            end else if (open_ff[pg] && pend_cnt_ff[pg] != '0) begin
               qi_in    = '0;
               kept_in  = '0;
               state_in = ST_RET_RD;
            end else begin
               p_in = p_ff + PCW'(1);
            end
         end
         ST_RET_RD: begin
            q_raddr  = {pg, qi_ff[QIW-1:0]};
            state_in = ST_RET_CHK;
         end
         ST_RET_CHK: begin
            ent_in = qcur;
            if (qcur.fence <= fence_ff) begin
               pos_in      = '0;
               has_prev_in = 1'b0;
               state_in    = (free_cnt_ff[pg] == '0) ? ST_GB_END : ST_GB_RD;
            end else begin
               state_in = ST_KEEP;
            end
         end
         ST_KEEP: begin
            q_we     = 1'b1;
            q_waddr  = {pg, kept_ff[QIW-1:0]};
            q_wdata  = ent_ff;
            kept_in  = kept_ff + QCW'(1);
            state_in = ST_RET_NEXT;
         end
         ST_RET_NEXT: begin
            if (qi_inc < pend_cnt_ff[pg]) begin
               qi_in    = qi_inc;
               state_in = ST_RET_RD;
            end else begin
               pend_cnt_in[pg] = kept_ff;
               p_in     = p_ff + PCW'(1);
               state_in = ST_RET_PAGE;
            end
         end
         ST_GB_RD: begin
            f_raddr  = {pg, pos_ff[FIW-1:0]};
            state_in = ST_GB_CHK;
         end
         ST_GB_CHK: begin
            if (fcur.rng_lo < ent_ff.rng_lo) begin
               prev_in     = fcur;
               has_prev_in = 1'b1;
               pos_in      = pos_inc;
               state_in    = (pos_inc == free_cnt_ff[pg]) ? ST_GB_END : ST_GB_RD;
            end else if (fcur.rng_lo != ent_ff.rng_hi) begin
               if (prev_join) begin
                  f_we     = 1'b1;
                  f_waddr  = {pg, pos_dec[FIW-1:0]};
                  f_wdata  = '{rng_hi: ent_ff.rng_hi, rng_lo: prev_ff.rng_lo};
                  state_in = ST_RET_NEXT;
               end else begin
                  k_in     = free_cnt_ff[pg];
                  state_in = ST_INS;
               end
            end else if (prev_join) begin
               // range bridges its two neighbors: widen the lower one, drop the upper
               f_we     = 1'b1;
               f_waddr  = {pg, pos_dec[FIW-1:0]};
               f_wdata  = '{rng_hi: fcur.rng_hi, rng_lo: prev_ff.rng_lo};
               k_in     = pos_ff;
               state_in = ST_REM;
            end else begin
               f_we     = 1'b1;
               f_waddr  = {pg, pos_ff[FIW-1:0]};
               f_wdata  = '{rng_hi: fcur.rng_hi, rng_lo: ent_ff.rng_lo};
               state_in = ST_RET_NEXT;
            end
         end
         ST_GB_END: begin
            if (prev_join) begin
               f_we     = 1'b1;
               f_waddr  = {pg, pos_dec[FIW-1:0]};
               f_wdata  = '{rng_hi: ent_ff.rng_hi, rng_lo: prev_ff.rng_lo};
               state_in = ST_RET_NEXT;
            end else begin
               k_in     = free_cnt_ff[pg];
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            if (free_cnt_ff[pg] >= FCW'(MAX_FREE_RANGES)) begin
               status_in = psa_pkg::STAT_FULL;
               state_in  = ST_KEEP;
            end else if (k_ff > pos_ff) begin
               f_raddr  = {pg, k_dec[FIW-1:0]};
               state_in = ST_INS_WR;
            end else begin
               f_we     = 1'b1;
               f_waddr  = {pg, pos_ff[FIW-1:0]};
               f_wdata  = '{rng_hi: ent_ff.rng_hi, rng_lo: ent_ff.rng_lo};
               free_cnt_in[pg] = free_cnt_ff[pg] + FCW'(1);
               state_in = ST_RET_NEXT;
            end
         end
         ST_INS_WR: begin
            f_we     = 1'b1;
            f_waddr  = {pg, k_ff[FIW-1:0]};
            f_wdata  = fcur;
            k_in     = k_dec;
            state_in = ST_INS;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = opage_ff;
               rsp_off_in    = ooff_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int n = 0; n < NP; n++) begin
            free_cnt_ff[n] <= '0;
            pend_cnt_ff[n] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         free_cnt_ff   <= free_cnt_in;
         pend_cnt_ff   <= pend_cnt_in;
      end
      mode_ff       <= mode_in;
      bpage_ff      <= bpage_in;
      boff_ff       <= boff_in;
      bbytes_ff     <= bbytes_in;
      fence_ff      <= fence_in;
      sz_ff         <= sz_in;
      status_ff     <= status_in;
      opage_ff      <= opage_in;
      ooff_ff       <= ooff_in;
      p_ff          <= p_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      qi_ff         <= qi_in;
      kept_ff       <= kept_in;
      ent_ff        <= ent_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_off_ff    <= rsp_off_in;
   end

   psa_size_unit u_size (
      .clock         (clock),
      .reset         (reset),
      .start         (size_start),
      .request_bytes (req_tdata[31:0]),
      .align_bytes   (req_tdata[41:32]),
      .result        (size_res)
   );

   psa_ram #(
      .WIDTH ($bits(psa_pkg::free_entry_type)),
      .DEPTH (NP << FIW)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (fcur)
   );

   psa_ram #(
      .WIDTH ($bits(psa_pkg::pend_entry_type)),
      .DEPTH (NP << QIW)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (qcur)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_off_ff, rsp_page_ff, rsp_status_ff};

endmodule
